// ===== rtl/core/ptr_pkg.sv =====
// Shared types and constants for the paged translation core.
// Field widths, replacement mode codes and control bundles between modules.
// No dependencies.
package ptr_pkg;

    // Field widths fixed by the interface
    localparam int VA_W    = 12;
    localparam int PA_W    = 10;
    localparam int EP_W    = 4;
    localparam int MODE_W  = 2;
    localparam int STAMP_W = 32;
    localparam int COUNT_W = 16;

    // Default geometry
    localparam int DEF_PAGE_BITS     = 8;
    localparam int DEF_VIRTUAL_PAGES = 16;
    localparam int DEF_FRAMES        = 4;

    // Saturation limits of the usage records
    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Replacement mode codes
    localparam logic [MODE_W-1:0] MODE_FIFO    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LRU     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LFU     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

    // Page table control
    typedef struct packed {
        logic rd_en;
        logic load_en;
        logic unmap_en;
    } t_pt_ctrl;

    // Frame record control
    typedef struct packed {
        logic capture;
        logic hit_en;
        logic load_en;
        logic fifo_pop;
    } t_fr_ctrl;

endpackage

// ===== rtl/core/ptr_page_table.sv =====
// Page table: synchronous frame-number memory plus present bits in flops.
// Uses ptr_pkg for the control bundle.
module ptr_page_table
    import ptr_pkg::*;
#(
    parameter int VIRTUAL_PAGES = DEF_VIRTUAL_PAGES,
    parameter int FRAMES        = DEF_FRAMES,
    localparam int PT_W = (VIRTUAL_PAGES > 2) ? $clog2(VIRTUAL_PAGES) : 1,
    localparam int FR_W = (FRAMES > 2) ? $clog2(FRAMES) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pt_ctrl                 i_ctrl,
    input  logic [PT_W-1:0]          i_rd_addr,
    input  logic [PT_W-1:0]          i_wr_addr,
    input  logic [FR_W-1:0]          i_wr_frame,
    input  logic [PT_W-1:0]          i_unmap_addr,
    output logic [FR_W-1:0]          o_rd_frame,
    output logic [VIRTUAL_PAGES-1:0] o_present
);

    logic [FR_W-1:0]          r_frame_mem [VIRTUAL_PAGES];
    logic [FR_W-1:0]          r_rd_frame;
    logic [VIRTUAL_PAGES-1:0] r_present;

    // Frame memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_en) begin
            r_frame_mem[i_wr_addr] <= i_wr_frame;
        end
        if (i_ctrl.rd_en) begin
            r_rd_frame <= r_frame_mem[i_rd_addr];
        end
    end

    // Present bits; a load wins over an unmap of the same page
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else begin
            if (i_ctrl.unmap_en) begin
                r_present[i_unmap_addr] <= 1'b0;
            end
            if (i_ctrl.load_en) begin
                r_present[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_frame = r_rd_frame;
    assign o_present  = r_present;

endmodule

// ===== rtl/core/ptr_frame_records.sv =====
// Per-frame usage records, access clock, FIFO ring and victim selection.
// Uses ptr_pkg for widths, mode codes and the control bundle.
module ptr_frame_records
    import ptr_pkg::*;
#(
    parameter int VIRTUAL_PAGES = DEF_VIRTUAL_PAGES,
    parameter int FRAMES        = DEF_FRAMES,
    localparam int PT_W = (VIRTUAL_PAGES > 2) ? $clog2(VIRTUAL_PAGES) : 1,
    localparam int FR_W = (FRAMES > 2) ? $clog2(FRAMES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fr_ctrl          i_ctrl,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [FR_W-1:0]   i_frame,
    input  logic [PT_W-1:0]   i_page,
    output logic              o_free_found,
    output logic [FR_W-1:0]   o_free_frame,
    output logic [FR_W-1:0]   o_repl_frame,
    output logic [PT_W-1:0]   o_repl_owner
);

    logic [STAMP_W-1:0] r_stamp [FRAMES];
    logic [COUNT_W-1:0] r_count [FRAMES];
    logic [FRAMES-1:0]  r_used;
    logic [PT_W-1:0]    r_owner [FRAMES];
    logic [FR_W-1:0]    r_fifo  [FRAMES];
    logic [FR_W-1:0]    r_head;
    logic [FR_W-1:0]    r_tail;
    logic [STAMP_W-1:0] r_clock;

    logic               r_free_found;
    logic [FR_W-1:0]    r_free_frame;
    logic [FR_W-1:0]    r_repl_frame;

    logic               free_found;
    logic [FR_W-1:0]    free_frame;
    logic [FR_W-1:0]    lru_frame;
    logic [FR_W-1:0]    lfu_frame;
    logic [FR_W-1:0]    repl_frame;
    logic [STAMP_W-1:0] clock_tick;
    logic [FR_W-1:0]    head_inc;
    logic [FR_W-1:0]    tail_inc;

    // Lowest free frame
    always_comb begin
        free_found = 1'b0;
        free_frame = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_frame = FR_W'(i);
            end
        end
    end

    // Minimum stamp and minimum count; ties keep the lower frame
    always_comb begin
        logic [STAMP_W-1:0] best_stamp;
        logic [COUNT_W-1:0] best_count;
        best_stamp = r_stamp[0];
        best_count = r_count[0];
        lru_frame  = '0;
        lfu_frame  = '0;
        for (int i = 1; i < FRAMES; i++) begin
            if (r_stamp[i] < best_stamp) begin
                best_stamp = r_stamp[i];
                lru_frame  = FR_W'(i);
            end
            if (r_count[i] < best_count) begin
                best_count = r_count[i];
                lfu_frame  = FR_W'(i);
            end
        end
    end

    // Victim by mode
    always_comb begin
        unique case (i_mode)
            MODE_LRU: repl_frame = lru_frame;
            MODE_LFU: repl_frame = lfu_frame;
            default:  repl_frame = r_fifo[r_head];
        endcase
    end

    // Victim choice is captured with the item, while the page table read runs
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_free_found <= free_found;
            r_free_frame <= free_frame;
            r_repl_frame <= repl_frame;
        end
    end

    assign clock_tick = (r_clock == STAMP_MAX) ? r_clock : r_clock + 1'b1;
    assign head_inc   = (r_head == FR_W'(FRAMES - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc   = (r_tail == FR_W'(FRAMES - 1)) ? '0 : r_tail + 1'b1;

    // Usage records, clock and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_clock <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_stamp[i] <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_ctrl.hit_en) begin
                r_clock <= clock_tick;
                if (i_mode == MODE_LRU) begin
                    r_stamp[i_frame] <= clock_tick;
                end else if (i_mode == MODE_LFU && r_count[i_frame] != COUNT_MAX) begin
                    r_count[i_frame] <= r_count[i_frame] + 1'b1;
                end
            end
            if (i_ctrl.load_en) begin
                r_clock          <= clock_tick;
                r_used[i_frame]  <= 1'b1;
                r_stamp[i_frame] <= clock_tick;
                r_count[i_frame] <= COUNT_W'(1);
                r_tail           <= tail_inc;
            end
            if (i_ctrl.fifo_pop) begin
                r_head <= head_inc;
            end
        end
    end

    // Owner and ring entries hold no reset value
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_en) begin
            r_owner[i_frame] <= i_page;
            r_fifo[r_tail]   <= i_frame;
        end
    end

    assign o_free_found = r_free_found;
    assign o_free_frame = r_free_frame;
    assign o_repl_frame = r_repl_frame;
    assign o_repl_owner = r_owner[r_repl_frame];

endmodule

// ===== rtl/core/paged_translation_with_replacement_core.sv =====
// Top level of the paged translation core with FIFO/LRU/LFU replacement.
// Uses ptr_pkg, ptr_page_table and ptr_frame_records.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one virtual address per item.
//   Output channel: o_out_valid / i_out_stall carry one result per item:
//   physical address, page fault, eviction flag and page, error flag.
//   Config channel: i_cfg_valid / o_cfg_ready write the 2-bit replacement
//   mode (0 FIFO, 1 LRU, 2 LFU, 3 invalid); write it only while idle.
// Timing:
//   In IDLE an item is accepted while the synchronous page-table read and the
//   victim selection are registered; in EXEC it resolves hit or miss and writes
//   back, and the result enters the output register as EXEC ends. A new item is
//   accepted only in IDLE, after the page table read-modify-write of the last.
// Stall:
//   A result waits in the output register while i_out_stall is high. The next
//   item is still accepted and finishes once the register frees.
// Reset:
//   Synchronous, active low. All pages absent, all frames free, usage records
//   and the access clock zero, mode FIFO, output empty.
module paged_translation_with_replacement_core
    import ptr_pkg::*;
#(
    parameter int PAGE_BITS     = DEF_PAGE_BITS,
    parameter int VIRTUAL_PAGES = DEF_VIRTUAL_PAGES,
    parameter int FRAMES        = DEF_FRAMES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [VA_W-1:0]   i_virtual_address,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [PA_W-1:0]   o_phys_addr,
    output logic              o_page_fault,
    output logic              o_evicted,
    output logic [EP_W-1:0]   o_evicted_page,
    output logic              o_error,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MODE_W-1:0] i_cfg_data
);

    localparam int PT_W = (VIRTUAL_PAGES > 2) ? $clog2(VIRTUAL_PAGES) : 1;
    localparam int FR_W = (FRAMES > 2) ? $clog2(FRAMES) : 1;
    localparam int PH_W = FR_W + VA_W;
    localparam int EV_W = (PT_W > EP_W) ? PT_W : EP_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                 r_state, n_state;
    logic [MODE_W-1:0]    r_mode;
    logic [PT_W-1:0]      r_page;
    logic [PAGE_BITS-1:0] r_offset;
    logic                 r_oor;

    logic                 r_out_valid;
    logic [PA_W-1:0]      r_phys;
    logic                 r_fault;
    logic                 r_evicted;
    logic [EP_W-1:0]      r_ev_page;
    logic                 r_error;

    t_pt_ctrl             pt_ctrl;
    t_fr_ctrl             fr_ctrl;
    logic [FR_W-1:0]      pt_rd_frame;
    logic [VIRTUAL_PAGES-1:0] pt_present;
    logic                 fr_free_found;
    logic [FR_W-1:0]      fr_free_frame;
    logic [FR_W-1:0]      fr_repl_frame;
    logic [PT_W-1:0]      fr_repl_owner;

    logic                 accept;
    logic                 out_free;
    logic                 done;
    logic [VA_W-1:0]      in_page;
    logic                 present;
    logic                 hit;
    logic                 miss;
    logic                 use_free;
    logic                 repl_ok;
    logic                 mode_err;
    logic                 evict;
    logic                 load;
    logic                 err;
    logic [FR_W-1:0]      frame_sel;
    logic [PH_W-1:0]      phys_full;
    logic [EV_W-1:0]      owner_ext;

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign done        = (r_state == S_EXEC) && out_free;
    assign o_cfg_ready = 1'b1;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FIFO;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Split the address when the item is taken
    assign in_page = VA_W'(i_virtual_address >> PAGE_BITS);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page   <= in_page[PT_W-1:0];
            r_offset <= i_virtual_address[PAGE_BITS-1:0];
            r_oor    <= (in_page >= VA_W'(VIRTUAL_PAGES));
        end
    end

    // Resolve hit, free load, replacement or error
    assign present   = pt_present[r_page];
    assign hit       = !r_oor && present;
    assign miss      = !r_oor && !present;
    assign use_free  = miss && fr_free_found;
    assign repl_ok   = miss && !fr_free_found && (r_mode != MODE_INVALID);
    assign mode_err  = miss && !fr_free_found && (r_mode == MODE_INVALID);
    // The owner of a used frame always maps back to it, so presence suffices
    assign evict     = repl_ok && pt_present[fr_repl_owner];
    assign load      = use_free || repl_ok;
    assign err       = r_oor || mode_err;
    assign frame_sel = hit ? pt_rd_frame : (use_free ? fr_free_frame : fr_repl_frame);

    assign phys_full = (PH_W'(frame_sel) << PAGE_BITS) | PH_W'(r_offset);
    assign owner_ext = EV_W'(fr_repl_owner);

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_phys    <= err ? '0 : phys_full[PA_W-1:0];
            r_fault   <= miss;
            r_evicted <= evict;
            r_ev_page <= evict ? owner_ext[EP_W-1:0] : '0;
            r_error   <= err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_phys_addr    = r_phys;
    assign o_page_fault   = r_fault;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_ev_page;
    assign o_error        = r_error;

    // Control to the state holders
    always_comb begin
        pt_ctrl.rd_en    = accept;
        pt_ctrl.load_en  = done && load;
        pt_ctrl.unmap_en = done && evict;
        fr_ctrl.capture  = accept;
        fr_ctrl.hit_en   = done && hit;
        fr_ctrl.load_en  = done && load;
        fr_ctrl.fifo_pop = done && repl_ok && (r_mode == MODE_FIFO);
    end

    ptr_page_table #(
        .VIRTUAL_PAGES (VIRTUAL_PAGES),
        .FRAMES        (FRAMES)
    ) u_page_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (pt_ctrl),
        .i_rd_addr    (in_page[PT_W-1:0]),
        .i_wr_addr    (r_page),
        .i_wr_frame   (frame_sel),
        .i_unmap_addr (fr_repl_owner),
        .o_rd_frame   (pt_rd_frame),
        .o_present    (pt_present)
    );

    ptr_frame_records #(
        .VIRTUAL_PAGES (VIRTUAL_PAGES),
        .FRAMES        (FRAMES)
    ) u_frame_records (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (fr_ctrl),
        .i_mode       (r_mode),
        .i_frame      (frame_sel),
        .i_page       (r_page),
        .o_free_found (fr_free_found),
        .o_free_frame (fr_free_frame),
        .o_repl_frame (fr_repl_frame),
        .o_repl_owner (fr_repl_owner)
    );

endmodule
